>>> design/source_route_duplicate_filter_top_assert.svh
// Assertion macros for the duplicate filter.
// Each macro expects i_clk and i_rst_n in scope.
`ifndef SOURCE_ROUTE_DUPLICATE_FILTER_TOP_ASSERT_SVH
`define SOURCE_ROUTE_DUPLICATE_FILTER_TOP_ASSERT_SVH

// Same-cycle implication
`define SRDF_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("srdf assertion failed");

// Next-cycle implication
`define SRDF_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("srdf assertion failed");

`endif

>>> design/srdf_pkg.sv
package srdf_pkg;

    // Default sizes
    localparam int STORE_DEPTH_DEF = 32;
    localparam int MAX_NODES_DEF   = 32;

    // Field widths
    localparam int REQ_W      = 2;
    localparam int MASK_W     = 32;
    localparam int BYTE_W     = 8;
    localparam int KEY_W      = 16;
    localparam int STAMP_W    = 16;
    localparam int NODE_W     = 5;
    localparam int LIFE_W     = 15;
    localparam int REASON_W   = 2;
    localparam int OCC_W      = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 15;

    // Key is direction * KEY_SCALE + seq, mod 2^16
    localparam logic [KEY_W-1:0] KEY_SCALE = 16'd1000;

    // Config reset values
    localparam logic [NODE_W-1:0] NODE_RESET = '0;
    localparam logic [LIFE_W-1:0] LIFE_RESET = 15'd1000;

    // Config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_INDEX = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIFETIME   = 1'b1;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_RECV = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SEND = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TICK = 2'd2;

    // Result reason codes
    localparam logic [REASON_W-1:0] RSN_ACCEPT    = 2'd0;
    localparam logic [REASON_W-1:0] RSN_OFF_ROUTE = 2'd1;
    localparam logic [REASON_W-1:0] RSN_DUP       = 2'd2;
    localparam logic [REASON_W-1:0] RSN_TICK      = 2'd3;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SEARCH,
        ST_APPEND,
        ST_TICK_RD,
        ST_TICK_CMP,
        ST_OUT
    } t_state;

endpackage

>>> design/source_route_duplicate_filter_top.sv
// Sequence: a receive goes to decide, then to out when off route, else to search (one
//   compare a cycle, from the oldest key) and to out on a duplicate, or to append and
//   out; a local send goes decide, append, out; an undefined request goes decide, out;
//   a tick reads and compares oldest stamps, expiring keys until one survives or none is left.
// Throughput: one item at a time; the next item is accepted after the result is taken.
//   Config writes are always ready. Reset (synchronous, active low) clears
//   pointers, count, time and config to defaults; key and stamp memories are kept.
module source_route_duplicate_filter_top #(
    parameter int STORE_DEPTH = srdf_pkg::STORE_DEPTH_DEF,
    parameter int MAX_NODES   = srdf_pkg::MAX_NODES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // config write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [srdf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [srdf_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // input item channel
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [srdf_pkg::REQ_W-1:0]       i_req_type,
    input  logic [srdf_pkg::MASK_W-1:0]      i_route_mask,
    input  logic [srdf_pkg::BYTE_W-1:0]      i_direction,
    input  logic [srdf_pkg::BYTE_W-1:0]      i_seq_number,
    // result channel
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_accepted,
    output logic [srdf_pkg::REASON_W-1:0]    o_reason,
    output logic                             o_evicted,
    output logic [srdf_pkg::OCC_W-1:0]       o_occupancy,
    output logic [srdf_pkg::KEY_W-1:0]       o_dup_key
);
    import srdf_pkg::*;

    localparam int PTR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CNT_W = $clog2(STORE_DEPTH + 1);
    localparam int SUM_W = PTR_W + 1;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(STORE_DEPTH);
    localparam logic [SUM_W-1:0] DEPTH_S  = SUM_W'(STORE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(STORE_DEPTH - 1);
    localparam logic [NODE_W:0]  NODES_LIM = (NODE_W + 1)'(MAX_NODES);

    // circular pointer step
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == LAST_PTR) ? '0 : p + 1'b1;
    endfunction

    // control state
    t_state              r_state, n_state;
    logic [PTR_W-1:0]    r_head, n_head;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [STAMP_W-1:0]  r_time, n_time;
    logic [NODE_W-1:0]   r_node_index;
    logic [LIFE_W-1:0]   r_lifetime;
    logic [PTR_W-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]    r_idx, n_idx;
    logic                r_cmp_vld, n_cmp_vld;

    // item payload
    logic [REQ_W-1:0]    r_req;
    logic [MASK_W-1:0]   r_mask;
    logic [KEY_W-1:0]    r_key;
    logic [KEY_W-1:0]    n_key;

    // result payload
    logic                r_res_acc, n_res_acc;
    logic [REASON_W-1:0] r_res_reason, n_res_reason;
    logic                r_res_ev, n_res_ev;
    logic [KEY_W-1:0]    r_res_key, n_res_key;

    // memories
    logic [KEY_W-1:0]    key_mem   [STORE_DEPTH];
    logic [STAMP_W-1:0]  stamp_mem [STORE_DEPTH];
    logic [KEY_W-1:0]    r_rd_key;
    logic [STAMP_W-1:0]  r_rd_stamp;
    logic [PTR_W-1:0]    rd_addr;
    logic [PTR_W-1:0]    wr_addr;
    logic                wr_en;

    logic                in_take;
    logic                on_route;
    logic                key_hit;
    logic [SUM_W-1:0]    tail_sum;
    logic [PTR_W-1:0]    tail_ptr;
    logic [STAMP_W-1:0]  age;

    // handshakes
    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = (r_state == ST_OUT);
    assign in_take     = i_in_valid && !o_in_stall;

    // key of the incoming item
    assign n_key = KEY_W'(KEY_W'(i_direction) * KEY_SCALE) + KEY_W'(i_seq_number);

    // route check, node index at or beyond MAX_NODES is off route
    assign on_route = ((NODE_W + 1)'(r_node_index) < NODES_LIM) && r_mask[r_node_index];

    // append slot: (head + count) mod depth
    assign tail_sum = SUM_W'(r_head) + SUM_W'(r_count);
    assign tail_ptr = (tail_sum >= DEPTH_S) ? PTR_W'(tail_sum - DEPTH_S) : PTR_W'(tail_sum);

    // compare logic on the registered memory read data
    assign key_hit = r_cmp_vld && (r_rd_key == r_key);
    assign age     = r_time - r_rd_stamp;

    // outputs
    assign o_accepted  = r_res_acc;
    assign o_reason    = r_res_reason;
    assign o_evicted   = r_res_ev;
    assign o_occupancy = OCC_W'(r_count);
    assign o_dup_key   = r_res_key;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_head       <= '0;
            r_count      <= '0;
            r_time       <= '0;
            r_node_index <= NODE_RESET;
            r_lifetime   <= LIFE_RESET;
            r_rd_ptr     <= '0;
            r_idx        <= '0;
            r_cmp_vld    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_count   <= n_count;
            r_time    <= n_time;
            r_rd_ptr  <= n_rd_ptr;
            r_idx     <= n_idx;
            r_cmp_vld <= n_cmp_vld;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_NODE_INDEX: r_node_index <= i_cfg_data[NODE_W-1:0];
                    CFG_LIFETIME:   r_lifetime   <= i_cfg_data[LIFE_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // item and result payload
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_req  <= i_req_type;
            r_mask <= i_route_mask;
            r_key  <= n_key;
        end
        r_res_acc    <= n_res_acc;
        r_res_reason <= n_res_reason;
        r_res_ev     <= n_res_ev;
        r_res_key    <= n_res_key;
    end

    // key and stamp memories, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            key_mem[wr_addr]   <= r_key;
            stamp_mem[wr_addr] <= r_time;
        end
        r_rd_key   <= key_mem[rd_addr];
        r_rd_stamp <= stamp_mem[rd_addr];
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_count      = r_count;
        n_time       = r_time;
        n_rd_ptr     = r_rd_ptr;
        n_idx        = r_idx;
        n_cmp_vld    = r_cmp_vld;
        n_res_acc    = r_res_acc;
        n_res_reason = r_res_reason;
        n_res_ev     = r_res_ev;
        n_res_key    = r_res_key;
        rd_addr      = r_rd_ptr;
        wr_addr      = tail_ptr;
        wr_en        = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    n_state = ST_DECIDE;
                end
            end

            ST_DECIDE: begin
                // defaults cover tick and undefined request
                n_res_acc    = 1'b0;
                n_res_reason = RSN_TICK;
                n_res_ev     = 1'b0;
                n_res_key    = '0;
                n_rd_ptr     = r_head;
                n_idx        = '0;
                n_cmp_vld    = 1'b0;
                unique case (r_req)
                    REQ_RECV: begin
                        n_res_key = r_key;
                        if (!on_route) begin
                            n_res_reason = RSN_OFF_ROUTE;
                            n_state      = ST_OUT;
                        end else begin
                            n_state = ST_SEARCH;
                        end
                    end
                    REQ_SEND: begin
                        n_res_key = r_key;
                        n_state   = ST_APPEND;
                    end
                    REQ_TICK: begin
                        n_time  = r_time + 1'b1;
                        n_state = ST_TICK_RD;
                    end
                    default: begin
                        n_state = ST_OUT;
                    end
                endcase
            end

            // one read issued and one compare done per cycle
            ST_SEARCH: begin
                if (key_hit) begin
                    n_res_reason = RSN_DUP;
                    n_cmp_vld    = 1'b0;
                    n_state      = ST_OUT;
                end else if ((r_idx == r_count) && !r_cmp_vld) begin
                    n_state = ST_APPEND;
                end else if (r_idx != r_count) begin
                    rd_addr   = r_rd_ptr;
                    n_rd_ptr  = ptr_inc(r_rd_ptr);
                    n_idx     = r_idx + 1'b1;
                    n_cmp_vld = 1'b1;
                end else begin
                    n_cmp_vld = 1'b0;
                end
            end

            // store key, evicting the oldest when full
            ST_APPEND: begin
                wr_en        = 1'b1;
                n_res_acc    = 1'b1;
                n_res_reason = RSN_ACCEPT;
                if (r_count == FULL_CNT) begin
                    wr_addr  = r_head;
                    n_head   = ptr_inc(r_head);
                    n_res_ev = 1'b1;
                end else begin
                    wr_addr = tail_ptr;
                    n_count = r_count + 1'b1;
                end
                n_state = ST_OUT;
            end

            // expiry: read oldest stamp
            ST_TICK_RD: begin
                rd_addr = r_head;
                if (r_count == '0) begin
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_TICK_CMP;
                end
            end

            ST_TICK_CMP: begin
                if (age >= STAMP_W'(r_lifetime)) begin
                    n_head  = ptr_inc(r_head);
                    n_count = r_count - 1'b1;
                    n_state = ST_TICK_RD;
                end else begin
                    n_state = ST_OUT;
                end
            end

            ST_OUT: begin
                if (!i_out_stall) begin
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // checks
    `include "source_route_duplicate_filter_top_assert.svh"

    `SRDF_ASSERT_NOW(a_count_bound, 1'b1, r_count <= FULL_CNT)
    `SRDF_ASSERT_NOW(a_evict_full, o_out_valid && o_evicted, r_count == FULL_CNT)
    `SRDF_ASSERT_NOW(a_accept_nonempty, o_out_valid && o_accepted, r_count != '0)
    `SRDF_ASSERT_NEXT(a_take_decide, in_take, r_state == ST_DECIDE)
    `SRDF_ASSERT_NEXT(a_write_result, wr_en, o_out_valid && o_accepted)

endmodule
